@@ src/rprb_pkg.sv @@
// shared types, constants and sizes for the reliable packet reorder buffer
package rprb_pkg;

    localparam int SEQ_BITS      = 16;
    localparam int COUNT_BITS    = 64;
    localparam int TAG_IN_BITS   = 32;
    localparam int WINDOW_SLOTS  = 32;
    localparam int TAG_BITS      = 32;
    localparam int SLOT_BITS     = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int SLOT_SUM_BITS = SLOT_BITS + 1;
    localparam int TAG_KEEP_BITS = (TAG_BITS < TAG_IN_BITS) ? TAG_BITS : TAG_IN_BITS;

    localparam logic [SEQ_BITS-1:0] HALF_RANGE = 16'h8000;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_BITS-1:0]    packet_seqnum;
        logic [TAG_IN_BITS-1:0] payload_tag;
    } in_item_t;

    typedef struct packed {
        logic                   result_kind;
        logic [SEQ_BITS-1:0]    out_seqnum;
        logic [TAG_IN_BITS-1:0] out_tag;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic                 drop;
        logic                 deliver;
        logic                 hold;
        logic [SLOT_BITS-1:0] hold_slot;
    } class_t;

endpackage

@@ src/rprb_classify.sv @@
// sequence extension around the expected count and window classification
module rprb_classify (
    input  logic [rprb_pkg::COUNT_BITS-1:0] next_expected,
    input  logic [rprb_pkg::SLOT_BITS-1:0]  base_slot,
    input  logic [rprb_pkg::SEQ_BITS-1:0]   packet_seqnum,
    output rprb_pkg::class_t                cls
);

    logic [rprb_pkg::SEQ_BITS-1:0]      low;
    logic [rprb_pkg::SEQ_BITS-1:0]      fwd;
    logic [rprb_pkg::SEQ_BITS-1:0]      bwd;
    logic [rprb_pkg::SEQ_BITS:0]        low_sum;
    logic                               upper_zero;
    logic                               upper_ones;
    logic                               use_fwd;
    logic                               ahead_ok;
    logic [rprb_pkg::SLOT_SUM_BITS-1:0] slot_sum;

    always_comb begin
        low        = next_expected[rprb_pkg::SEQ_BITS-1:0];
        fwd        = packet_seqnum - low;
        bwd        = low - packet_seqnum;
        upper_zero = (next_expected[rprb_pkg::COUNT_BITS-1:rprb_pkg::SEQ_BITS] == '0);
        upper_ones = &next_expected[rprb_pkg::COUNT_BITS-1:rprb_pkg::SEQ_BITS];
        low_sum    = {1'b0, low} + {1'b0, fwd};
        // backward step past zero is taken as forward instead
        use_fwd    = (fwd <= rprb_pkg::HALF_RANGE) || (upper_zero && (bwd > low));
        // forward step that wraps the 64-bit count lands behind
        ahead_ok   = use_fwd && !(upper_ones && low_sum[rprb_pkg::SEQ_BITS]);

        cls.drop    = ahead_ok && (fwd > rprb_pkg::SEQ_BITS'(rprb_pkg::WINDOW_SLOTS));
        cls.deliver = ahead_ok && (fwd == '0);
        cls.hold    = ahead_ok && (fwd != '0)
                      && (fwd <= rprb_pkg::SEQ_BITS'(rprb_pkg::WINDOW_SLOTS));

        slot_sum = rprb_pkg::SLOT_SUM_BITS'(base_slot) + fwd[rprb_pkg::SLOT_SUM_BITS-1:0];
        if (slot_sum >= rprb_pkg::SLOT_SUM_BITS'(rprb_pkg::WINDOW_SLOTS)) begin
            slot_sum = slot_sum - rprb_pkg::SLOT_SUM_BITS'(rprb_pkg::WINDOW_SLOTS);
        end
        cls.hold_slot = slot_sum[rprb_pkg::SLOT_BITS-1:0];
    end

endmodule

@@ src/reliable_packet_reorder_buffer_core.sv @@
// reorder buffer top level: window tag memory, drain sequencer and result register
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      in_item_t  (packet_seqnum, payload_tag)
//   m_        out        m_valid / m_ready      out_item_t (kind, seqnum, tag, last)
//   cfg_      in         cfg_valid / cfg_ready  initial_seqnum
//
// an accepted item moves to the ack state, which loads its ack into the result register
// in-order delivery adds a deliver step for the expected packet and a drain step
// per held successor, paced by the single read port of the tag memory; a dropped
// item gives no result; a configuration write, taken only when idle, clears the window
// reset is synchronous active low and restarts at count 0 with an empty window
// a stalled result register stalls the sequencer; the next item is taken once the
// last result of the previous one sits in the result register
module reliable_packet_reorder_buffer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rprb_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rprb_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rprb_pkg::SEQ_BITS-1:0] cfg_initial_seqnum
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_DELIVER,
        ST_DRAIN
    } state_t;

    state_t                               state_reg;
    logic [rprb_pkg::COUNT_BITS-1:0]      expected_reg;
    logic [rprb_pkg::SLOT_BITS-1:0]       ptr_reg;
    logic [rprb_pkg::WINDOW_SLOTS-1:0]    valid_reg;
    logic [rprb_pkg::SEQ_BITS-1:0]        seq_reg;
    logic [rprb_pkg::TAG_KEEP_BITS-1:0]   tag_reg;
    logic                                 ack_last_reg;
    logic                                 m_valid_reg;
    rprb_pkg::out_item_t                  m_data_reg;
    logic [rprb_pkg::TAG_KEEP_BITS-1:0]   rd_data_reg;

    logic [rprb_pkg::TAG_KEEP_BITS-1:0]   tag_mem [rprb_pkg::WINDOW_SLOTS];

    rprb_pkg::class_t                     cls;
    logic                                 in_acc;
    logic                                 cfg_acc;
    logic                                 out_free;
    logic                                 out_load;
    logic [rprb_pkg::SLOT_BITS-1:0]       ptr_plus1;
    logic                                 next_held;
    logic                                 rd_en;

    rprb_classify u_classify (
        .next_expected (expected_reg),
        .base_slot     (ptr_reg),
        .packet_seqnum (s_data.packet_seqnum),
        .cls           (cls)
    );

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = out_free && (state_reg != ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        if (ptr_reg == rprb_pkg::SLOT_BITS'(rprb_pkg::WINDOW_SLOTS - 1)) begin
            ptr_plus1 = '0;
        end else begin
            ptr_plus1 = ptr_reg + rprb_pkg::SLOT_BITS'(1);
        end
        next_held = valid_reg[ptr_plus1];
        rd_en     = out_free && ((state_reg == ST_DELIVER) || (state_reg == ST_DRAIN));
    end

    // window tag memory: written on hold, read one slot ahead when delivering or draining
    always_ff @(posedge aclk) begin
        if (in_acc && cls.hold && !valid_reg[cls.hold_slot]) begin
            tag_mem[cls.hold_slot] <= s_data.payload_tag[rprb_pkg::TAG_KEEP_BITS-1:0];
        end
        if (rd_en) begin
            rd_data_reg <= tag_mem[ptr_plus1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            expected_reg <= '0;
            ptr_reg      <= '0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        // slots are numbered from the start count, so the window
                        // restarts at slot 0
                        expected_reg <= rprb_pkg::COUNT_BITS'(cfg_initial_seqnum);
                        valid_reg    <= '0;
                        ptr_reg      <= '0;
                    end else if (in_acc) begin
                        seq_reg      <= s_data.packet_seqnum;
                        tag_reg      <= s_data.payload_tag[rprb_pkg::TAG_KEEP_BITS-1:0];
                        ack_last_reg <= !cls.deliver;
                        if (cls.hold) begin
                            // first copy of a duplicate wins
                            valid_reg[cls.hold_slot] <= 1'b1;
                        end
                        if (!cls.drop) begin
                            state_reg <= ST_ACK;
                        end
                    end
                end
                ST_ACK: begin
                    if (out_free) begin
                        m_data_reg.result_kind <= rprb_pkg::KIND_ACK;
                        m_data_reg.out_seqnum  <= seq_reg;
                        m_data_reg.out_tag     <= '0;
                        m_data_reg.last        <= ack_last_reg;
                        state_reg              <= ack_last_reg ? ST_IDLE : ST_DELIVER;
                    end
                end
                ST_DELIVER: begin
                    if (out_free) begin
                        m_data_reg.result_kind <= rprb_pkg::KIND_DELIVER;
                        m_data_reg.out_seqnum  <= expected_reg[rprb_pkg::SEQ_BITS-1:0];
                        m_data_reg.out_tag     <= rprb_pkg::TAG_IN_BITS'(tag_reg);
                        m_data_reg.last        <= !next_held;
                        expected_reg           <= expected_reg + rprb_pkg::COUNT_BITS'(1);
                        ptr_reg                <= ptr_plus1;
                        state_reg              <= next_held ? ST_DRAIN : ST_IDLE;
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        m_data_reg.result_kind <= rprb_pkg::KIND_DELIVER;
                        m_data_reg.out_seqnum  <= expected_reg[rprb_pkg::SEQ_BITS-1:0];
                        m_data_reg.out_tag     <= rprb_pkg::TAG_IN_BITS'(rd_data_reg);
                        m_data_reg.last        <= !next_held;
                        valid_reg[ptr_reg]     <= 1'b0;
                        expected_reg           <= expected_reg + rprb_pkg::COUNT_BITS'(1);
                        ptr_reg                <= ptr_plus1;
                        state_reg              <= next_held ? ST_DRAIN : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a held packet is marked present right after its transaction
    a_hold_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && cls.hold) |=> valid_reg[$past(cls.hold_slot)])
        else $error("held packet not marked in window");

    // the drain only ever reads slots that are present
    a_drain_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> valid_reg[ptr_reg])
        else $error("drain reached an empty slot");

    // a restart empties the window
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> (valid_reg == '0) && (state_reg == ST_IDLE))
        else $error("configuration write did not clear the window");

    // a dropped packet yields no result
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && cls.drop) |=> (state_reg == ST_IDLE))
        else $error("dropped packet started a result");

endmodule

@@ verif/rprb_checker.sv @@
// scoreboard for the reorder buffer: predicts acks and in-order deliveries and compares them
module rprb_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  rprb_pkg::in_item_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  rprb_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rprb_pkg::SEQ_BITS-1:0] cfg_initial_seqnum,
    output int                            error_count,
    output int                            pending_count,
    output int                            result_count
);

    localparam logic [rprb_pkg::TAG_IN_BITS-1:0] TAG_MASK =
        {rprb_pkg::TAG_IN_BITS{1'b1}} >> (rprb_pkg::TAG_IN_BITS - rprb_pkg::TAG_KEEP_BITS);

    logic [rprb_pkg::SEQ_BITS-1:0]    start_seqnum;
    logic [rprb_pkg::COUNT_BITS-1:0]  expected_count;
    logic                             slot_held    [rprb_pkg::WINDOW_SLOTS];
    logic [rprb_pkg::TAG_IN_BITS-1:0] slot_payload [rprb_pkg::WINDOW_SLOTS];
    rprb_pkg::out_item_t              awaited_results [$];

    int mismatches      = 0;
    int results_checked = 0;
    int outstanding     = 0;

    assign error_count   = mismatches;
    assign pending_count = outstanding;
    assign result_count  = results_checked;

    function automatic rprb_pkg::out_item_t make_result(
            input logic kind,
            input logic [rprb_pkg::COUNT_BITS-1:0] count,
            input logic [rprb_pkg::TAG_IN_BITS-1:0] tag);
        rprb_pkg::out_item_t r;
        r.result_kind = kind;
        r.out_seqnum  = count[rprb_pkg::SEQ_BITS-1:0];
        r.out_tag     = tag & TAG_MASK;
        r.last        = 1'b0;
        return r;
    endfunction

    // soft restart: window emptied, counter loaded from the start register
    task automatic restart_window();
        expected_count = rprb_pkg::COUNT_BITS'(start_seqnum);
        for (int i = 0; i < rprb_pkg::WINDOW_SLOTS; i++) begin
            slot_held[i] = 1'b0;
        end
    endtask

    task automatic predict_arrival(input rprb_pkg::in_item_t pkt);
        logic [rprb_pkg::SEQ_BITS-1:0]    ahead;
        logic [rprb_pkg::SEQ_BITS-1:0]    behind;
        logic [rprb_pkg::COUNT_BITS-1:0]  full_count;
        logic [rprb_pkg::TAG_IN_BITS-1:0] tag;
        rprb_pkg::out_item_t              burst [rprb_pkg::WINDOW_SLOTS+2];
        int                               n;
        int                               slot;
        n      = 0;
        tag    = pkt.payload_tag & TAG_MASK;
        ahead  = pkt.packet_seqnum - expected_count[rprb_pkg::SEQ_BITS-1:0];
        behind = expected_count[rprb_pkg::SEQ_BITS-1:0] - pkt.packet_seqnum;
        // nearest full count, never stepping back past zero
        if (ahead <= rprb_pkg::HALF_RANGE ||
            rprb_pkg::COUNT_BITS'(behind) > expected_count)
            full_count = expected_count + rprb_pkg::COUNT_BITS'(ahead);
        else
            full_count = expected_count - rprb_pkg::COUNT_BITS'(behind);
        if (full_count >= expected_count &&
            full_count - expected_count > rprb_pkg::COUNT_BITS'(rprb_pkg::WINDOW_SLOTS))
            return;
        burst[n] = make_result(rprb_pkg::KIND_ACK, full_count, '0);
        n++;
        if (full_count == expected_count) begin
            burst[n] = make_result(rprb_pkg::KIND_DELIVER, full_count, tag);
            n++;
            expected_count = expected_count + 1;
            for (int i = 0; i < rprb_pkg::WINDOW_SLOTS; i++) begin
                slot = int'(expected_count % rprb_pkg::COUNT_BITS'(rprb_pkg::WINDOW_SLOTS));
                if (!slot_held[slot])
                    break;
                burst[n] = make_result(rprb_pkg::KIND_DELIVER, expected_count,
                                       slot_payload[slot]);
                n++;
                slot_held[slot] = 1'b0;
                expected_count = expected_count + 1;
            end
        end else if (full_count > expected_count) begin
            slot = int'(full_count % rprb_pkg::COUNT_BITS'(rprb_pkg::WINDOW_SLOTS));
            // first copy of a duplicate wins
            if (!slot_held[slot]) begin
                slot_held[slot]    = 1'b1;
                slot_payload[slot] = tag;
            end
        end
        burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            awaited_results.push_back(burst[i]);
        end
    endtask

    task automatic check_result(input rprb_pkg::out_item_t got);
        rprb_pkg::out_item_t want;
        logic                bad;
        if (awaited_results.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: kind %0d seq %04h tag %08h last %0d",
                         got.result_kind, got.out_seqnum, got.out_tag, got.last);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        results_checked++;
        bad = (got.result_kind !== want.result_kind) ||
              (got.out_seqnum  !== want.out_seqnum)  ||
              (got.out_tag     !== want.out_tag)     ||
              (got.last        !== want.last);
        if (bad) begin
            if (mismatches < 10)
                $display({"result mismatch: expected kind %0d seq %04h tag %08h last %0d,",
                          " got kind %0d seq %04h tag %08h last %0d"},
                         want.result_kind, want.out_seqnum, want.out_tag, want.last,
                         got.result_kind, got.out_seqnum, got.out_tag, got.last);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_seqnum = '0;
            restart_window();
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_valid && cfg_ready) begin
                start_seqnum = cfg_initial_seqnum;
                restart_window();
            end
            if (s_valid && s_ready)
                predict_arrival(s_data);
        end
        outstanding = awaited_results.size();
    end

endmodule

@@ verif/reliable_packet_reorder_buffer_core_tb.sv @@
// testbench top for the reorder buffer: clock, reset, stimulus phases and verdict
module reliable_packet_reorder_buffer_core_tb;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 40;

    typedef enum int {NOISE_OLD, NOISE_FAR, NOISE_ANY, NOISE_NEAR} noise_kind_t;

    logic                          aclk               = 1'b0;
    logic                          aresetn            = 1'b0;
    logic                          s_valid            = 1'b0;
    logic                          s_ready;
    rprb_pkg::in_item_t            s_data             = '0;
    logic                          m_valid;
    logic                          m_ready            = 1'b0;
    rprb_pkg::out_item_t           m_data;
    logic                          cfg_valid          = 1'b0;
    logic                          cfg_ready;
    logic [rprb_pkg::SEQ_BITS-1:0] cfg_initial_seqnum = '0;

    int error_count;
    int pending_count;
    int result_count;

    int                            idle_pct       = 0;
    int                            stall_pct      = 0;
    int                            cycle_count    = 0;
    int                            packets_sent   = 0;
    int                            starts_written = 0;
    logic [rprb_pkg::SEQ_BITS-1:0] cursor         = '0;

    reliable_packet_reorder_buffer_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data             (s_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_initial_seqnum (cfg_initial_seqnum)
    );

    rprb_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data             (s_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_initial_seqnum (cfg_initial_seqnum),
        .error_count        (error_count),
        .pending_count      (pending_count),
        .result_count       (result_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays up into the next transaction when no idle cycle is drawn
    task automatic send_packet(input logic [rprb_pkg::SEQ_BITS-1:0] seq,
                               input logic [rprb_pkg::TAG_IN_BITS-1:0] tag);
        while (int'($urandom_range(99)) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {seq, tag};
        do @(posedge aclk); while (!s_ready);
        packets_sent++;
    endtask

    task automatic hold_until_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        // dropped packets leave no result behind, so let the block settle
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start(input logic [rprb_pkg::SEQ_BITS-1:0] value);
        hold_until_idle();
        cfg_valid          <= 1'b1;
        cfg_initial_seqnum <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cursor = value;
        starts_written++;
    endtask

    task automatic send_noise();
        noise_kind_t kind;
        kind = noise_kind_t'($urandom_range(3));
        case (kind)
            NOISE_OLD:  send_packet(cursor - rprb_pkg::SEQ_BITS'($urandom_range(30000, 1)),
                                    $urandom);
            NOISE_FAR:  send_packet(cursor + rprb_pkg::SEQ_BITS'($urandom_range(32768,
                                    2 * rprb_pkg::WINDOW_SLOTS + 2)), $urandom);
            NOISE_ANY:  send_packet(rprb_pkg::SEQ_BITS'($urandom), $urandom);
            NOISE_NEAR: send_packet(cursor + rprb_pkg::SEQ_BITS'(
                                    $urandom_range(rprb_pkg::WINDOW_SLOTS)), $urandom);
            default:    send_packet(cursor, $urandom);
        endcase
    endtask

    // consecutive run from the cursor, shuffled (reversed if over the window), maybe one missing
    task automatic send_run(input int count);
        int order [rprb_pkg::WINDOW_SLOTS+1];
        int pick;
        int swap_val;
        int gap;
        for (int i = 0; i < count; i++) begin
            order[i] = (count > rprb_pkg::WINDOW_SLOTS) ? count - 1 - i : i;
        end
        if (count <= rprb_pkg::WINDOW_SLOTS) begin
            for (int i = count - 1; i > 0; i--) begin
                pick        = $urandom_range(i);
                swap_val    = order[i];
                order[i]    = order[pick];
                order[pick] = swap_val;
            end
        end
        gap = ($urandom_range(9) == 0) ? int'($urandom_range(count - 1)) : count;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15)
                send_noise();
            if (order[i] != gap)
                send_packet(cursor + rprb_pkg::SEQ_BITS'(order[i]), $urandom);
        end
        cursor = cursor + rprb_pkg::SEQ_BITS'(gap);
    endtask

    task automatic run_phase(input logic [rprb_pkg::SEQ_BITS-1:0] start, input int idle,
                             input int stall);
        int sent_before;
        write_start(start);
        idle_pct    = idle;
        stall_pct   = stall;
        sent_before = packets_sent;
        while (packets_sent - sent_before < PHASE_ITEMS) begin
            send_run(($urandom_range(9) == 0) ? rprb_pkg::WINDOW_SLOTS + 1
                                              : int'($urandom_range(8, 1)));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset the expected count is zero
        send_packet(16'h0000, 32'hFFFF_FFFF);
        send_packet(16'h0000, 32'h1234_5678);   // behind: ack only
        send_packet(16'hFFFF, 32'h0BAD_0001);   // backward would pass zero: far ahead, dropped
        send_packet(16'h8001, 32'h0BAD_0002);   // exactly half range ahead: dropped
        send_packet(16'h0003, 32'hA5A5_A5A5);
        send_packet(16'h0003, 32'h5A5A_5A5A);   // duplicate, first copy kept
        send_packet(16'h0002, 32'h0000_0000);
        send_packet(16'h0001, 32'h8000_0001);   // drains 2 and 3
        send_packet(16'h0024, 32'h7FFF_FFFE);   // last slot of the window
        send_packet(16'h0025, 32'h0BAD_0003);   // one past the window: dropped
        send_packet(16'h0004, 32'h0000_0004);

        write_start(16'hFFFE);
        send_packet(16'h0000, 32'h0000_0100);
        send_packet(16'hFFFF, 32'h0000_00FF);
        send_packet(16'hFFFE, 32'h0000_00FE);   // drain across the 16-bit wrap
        send_packet(16'hFFFE, 32'h0000_0BAD);
        send_packet(16'h8001, 32'h0BAD_0004);
        send_packet(16'h8002, 32'h0000_8002);   // extended backward
        send_packet(16'h0001, 32'hFFFF_0001);

        write_start(16'hFFFF);
        send_packet(16'hFFFF, 32'hC0DE_FFFF);
        send_packet(16'h7FFF, 32'h0BAD_0005);
        send_packet(16'h8000, 32'h0BAD_0006);
        send_packet(16'h8001, 32'h0000_8001);

        run_phase(16'hFFFF, 0, 0);
        run_phase(16'h0000, 87, 0);
        run_phase(16'h8000, 0, 87);
        run_phase(rprb_pkg::SEQ_BITS'($urandom), 18, 18);
        run_phase(16'hFFE8, 0, 0);

        hold_until_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d packets over %0d start values: in-order, shuffled, reversed,",
                 packets_sent, starts_written);
        $display("gapped and noisy runs; %0d results checked under four pacing modes",
                 result_count);
        if (error_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ reliable_packet_reorder_buffer_core.f @@
src/rprb_pkg.sv
src/rprb_classify.sv
src/reliable_packet_reorder_buffer_core.sv
verif/rprb_checker.sv
verif/reliable_packet_reorder_buffer_core_tb.sv
